// ===== rtl/core/bnfa_pkg.sv =====
package bnfa_pkg;

  localparam int IDX_W      = 10;
  localparam int FC_W       = 11;
  localparam int OFF_W      = 23;
  localparam int SLG_W      = 4;
  localparam int RLG_W      = 5;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  localparam int DEF_MAX_SLOTS      = 1024;
  localparam int DEF_SCAN_WORD_BITS = 64;

  localparam logic [SLG_W-1:0] SLG_MIN   = 4'd8;
  localparam logic [SLG_W-1:0] SLG_MAX   = 4'd10;
  localparam logic [SLG_W-1:0] SLG_RESET = 4'd10;
  localparam logic [RLG_W-1:0] RLG_MIN   = 5'd21;
  localparam logic [RLG_W-1:0] RLG_MAX   = 5'd23;
  localparam logic [RLG_W-1:0] RLG_RESET = 5'd22;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SLOT_COUNT_LOG2 = 1'b0,
    REG_REGION_LEN_LOG2 = 1'b1
  } cfg_reg_e;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_e;

  typedef enum logic [1:0] {
    ST_OK           = 2'd0,
    ST_NO_FREE      = 2'd1,
    ST_INCONSISTENT = 2'd2,
    ST_RANGE        = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SCAN,
    S_COMMIT,
    S_FREE_RD,
    S_FREE_WR
  } state_e;

  typedef struct packed {
    logic             req_type;
    logic [IDX_W-1:0] slot_index;
  } in_t;

  typedef struct packed {
    logic [1:0]       status;
    logic [IDX_W-1:0] granted_index;
    logic [OFF_W-1:0] slot_offset;
    logic [FC_W-1:0]  free_count;
  } out_t;

  typedef struct packed {
    logic clr;
    logic acc_alloc;
    logic acc_free;
    logic reject;
    logic scan;
    logic take_hit;
    logic fail;
    logic commit;
    logic free_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic clr_last;
    logic can_alloc;
    logic free_ok;
    logic hit;
    logic miss_done;
  } dp_status_t;

endpackage

// ===== rtl/core/bitmap_next_fit_slot_allocator.sv =====
// Next-fit slot allocator over an occupancy bitmap held in a word-wide memory.
// Input: a transaction is taken when start is high and busy is low; in_data
// carries the request kind (allocate or free) and the slot index to free.
// Output: each transaction yields exactly one result on out_data, shown for a
// single cycle with out_valid high; the receiver cannot hold it off.
// Configuration: cfg_we writes cfg_wdata into the register chosen by cfg_index
// (slot count log2, region length log2) at once; only write while idle.
// Sequence: a rejected request (no free slots, free index out of range) gives
// its result in the cycle after acceptance and the block is ready again at once.
// A free passes through a memory read state and then a write-back state.
// A successful allocate scans bitmap words and then commits the found slot in a
// write state; a search that finds nothing ends after its last word. The scan
// reads one word per cycle through the single memory read port, at most twice
// the number of words in use when the search wraps.
// Items are handled one at a time. Reset: the bitmap is cleared by a sweep
// over all MAX_SLOTS / SCAN_WORD_BITS words (16 by default), during which busy
// stays high; configuration writes are taken.
module bitmap_next_fit_slot_allocator #(
  parameter int MAX_SLOTS      = bnfa_pkg::DEF_MAX_SLOTS,
  parameter int SCAN_WORD_BITS = bnfa_pkg::DEF_SCAN_WORD_BITS
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            start,
  output logic                            busy,
  input  bnfa_pkg::in_t                   in_data,
  output logic                            out_valid,
  output bnfa_pkg::out_t                  out_data,
  input  logic                            cfg_we,
  input  logic [bnfa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [bnfa_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import bnfa_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t st;

  bnfa_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .req_type (in_data.req_type),
    .busy     (busy),
    .st       (st),
    .cmd      (cmd)
  );

  bnfa_dp #(
    .MAX_SLOTS      (MAX_SLOTS),
    .SCAN_WORD_BITS (SCAN_WORD_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .st        (st),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// ===== rtl/core/bnfa_ctrl.sv =====
module bnfa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic                  req_type,
  output logic                  busy,
  input  bnfa_pkg::dp_status_t  st,
  output bnfa_pkg::dp_cmd_t     cmd
);
  import bnfa_pkg::*;

  state_e state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    busy      = (state_r != S_IDLE);
    unique case (state_r)
      S_CLEAR: begin
        cmd.clr = 1'b1;
        if (st.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          if (req_type == REQ_ALLOC) begin
            if (st.can_alloc) begin
              cmd.acc_alloc = 1'b1;
              state_nxt     = S_SCAN;
            end else begin
              cmd.reject = 1'b1;
            end
          end else begin
            if (st.free_ok) begin
              cmd.acc_free = 1'b1;
              state_nxt    = S_FREE_RD;
            end else begin
              cmd.reject = 1'b1;
            end
          end
        end
      end
      S_SCAN: begin
        cmd.scan = 1'b1;
        if (st.hit) begin
          cmd.take_hit = 1'b1;
          state_nxt    = S_COMMIT;
        end else if (st.miss_done) begin
          cmd.fail  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      S_COMMIT: begin
        cmd.commit = 1'b1;
        state_nxt  = S_IDLE;
      end
      S_FREE_RD: begin
        state_nxt = S_FREE_WR;
      end
      S_FREE_WR: begin
        cmd.free_wr = 1'b1;
        state_nxt   = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/bnfa_dp.sv =====
module bnfa_dp #(
  parameter int MAX_SLOTS      = bnfa_pkg::DEF_MAX_SLOTS,
  parameter int SCAN_WORD_BITS = bnfa_pkg::DEF_SCAN_WORD_BITS
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [bnfa_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bnfa_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  input  bnfa_pkg::in_t                       in_data,
  input  bnfa_pkg::dp_cmd_t                   cmd,
  output bnfa_pkg::dp_status_t                st,
  output logic                                out_valid,
  output bnfa_pkg::out_t                      out_data
);
  import bnfa_pkg::*;

  localparam int SWB    = SCAN_WORD_BITS;
  localparam int SWB_LG = $clog2(SCAN_WORD_BITS);
  localparam int WORDS  = MAX_SLOTS / SCAN_WORD_BITS;
  localparam int WA_W   = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int MAX_LG = $clog2(MAX_SLOTS);

  function automatic logic [SLG_W-1:0] eff_lg(input logic [SLG_W-1:0] lg);
    logic [SLG_W-1:0] c;
    c = lg;
    if (c < SLG_MIN) c = SLG_MIN;
    if (c > SLG_MAX) c = SLG_MAX;
    if (c > SLG_W'(MAX_LG)) c = SLG_W'(MAX_LG);
    return c;
  endfunction

  logic [SWB-1:0] mem [WORDS];

  logic [SLG_W-1:0]  slg_r;
  logic [RLG_W-1:0]  rlg_r;
  logic [IDX_W-1:0]  next_start_r;
  logic [FC_W-1:0]   free_slots_r;
  logic [IDX_W-1:0]  scan_word_r;
  logic              pass_r;
  logic              issue_r;
  logic              first_pend_r;
  logic [SWB_LG-1:0] start_bit_r;
  logic              chk_valid_r;
  logic              chk_first_r;
  logic              chk_last_r;
  logic [IDX_W-1:0]  chk_word_r;
  logic [SWB-1:0]    rdata_r;
  logic [IDX_W-1:0]  hit_idx_r;
  logic [SWB-1:0]    wdata_r;
  logic [IDX_W-1:0]  free_idx_r;
  logic [WA_W-1:0]   clr_cnt_r;
  logic              out_valid_r;
  out_t              out_r;

  logic [SLG_W-1:0]  lg_e;
  logic [FC_W-1:0]   n;
  logic [FC_W-1:0]   n_words;
  logic [IDX_W-1:0]  last_word;
  logic [IDX_W-1:0]  start_word;
  logic              start_in;
  logic [RLG_W-1:0]  rlg_c;
  logic [RLG_W-1:0]  shamt;
  logic [OFF_W-1:0]  offset;
  logic [SWB-1:0]    mask;
  logic [SWB-1:0]    free_vec;
  logic [SWB_LG-1:0] enc;
  logic              hit;
  logic              mem_we;
  logic [WA_W-1:0]   mem_waddr;
  logic [SWB-1:0]    mem_wdata;
  logic [WA_W-1:0]   mem_raddr;

  always_comb begin
    lg_e       = eff_lg(slg_r);
    n          = FC_W'(1) << lg_e;
    n_words    = n >> SWB_LG;
    last_word  = IDX_W'(n_words - 1'b1);
    start_word = next_start_r >> SWB_LG;
    start_in   = ({1'b0, start_word} < n_words);
    rlg_c      = rlg_r;
    if (rlg_c < RLG_MIN) rlg_c = RLG_MIN;
    if (rlg_c > RLG_MAX) rlg_c = RLG_MAX;
    shamt  = rlg_c - {1'b0, lg_e};
    offset = OFF_W'(hit_idx_r) << shamt;
  end

  always_comb begin
    mask     = chk_first_r ? ({SWB{1'b1}} << start_bit_r) : {SWB{1'b1}};
    free_vec = ~rdata_r & mask;
    enc      = '0;
    for (int i = SWB - 1; i >= 0; i--) begin
      if (free_vec[i]) enc = SWB_LG'(i);
    end
    hit = chk_valid_r & (|free_vec);
  end

  always_comb begin
    st.clr_last  = (clr_cnt_r == WA_W'(WORDS - 1));
    st.can_alloc = (free_slots_r != '0);
    st.free_ok   = ({1'b0, in_data.slot_index} < n);
    st.hit       = hit;
    st.miss_done = chk_valid_r & ~hit & chk_last_r;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = clr_cnt_r;
    mem_wdata = '0;
    mem_raddr = WA_W'(scan_word_r);
    if (cmd.clr) begin
      mem_we = 1'b1;
    end else if (cmd.commit) begin
      mem_we    = 1'b1;
      mem_waddr = WA_W'(hit_idx_r >> SWB_LG);
      mem_wdata = wdata_r;
    end else if (cmd.free_wr) begin
      mem_we    = 1'b1;
      mem_waddr = WA_W'(scan_word_r);
      mem_wdata = rdata_r & ~(SWB'(1) << free_idx_r[SWB_LG-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slg_r        <= SLG_RESET;
      rlg_r        <= RLG_RESET;
      next_start_r <= '0;
      free_slots_r <= FC_W'(1) << eff_lg(SLG_RESET);
      issue_r      <= 1'b0;
      chk_valid_r  <= 1'b0;
      clr_cnt_r    <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      out_valid_r <= cmd.reject | cmd.fail | cmd.commit | cmd.free_wr;
      if (cmd.clr) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SLOT_COUNT_LOG2: begin
            slg_r        <= cfg_wdata[SLG_W-1:0];
            free_slots_r <= FC_W'(1) << eff_lg(cfg_wdata[SLG_W-1:0]);
          end
          REG_REGION_LEN_LOG2: begin
            rlg_r <= cfg_wdata;
          end
          default: begin
          end
        endcase
      end
      if (cmd.acc_alloc) begin
        issue_r     <= 1'b1;
        chk_valid_r <= 1'b0;
      end else if (cmd.scan) begin
        chk_valid_r <= issue_r;
        if (issue_r && pass_r && (scan_word_r == last_word)) begin
          issue_r <= 1'b0;
        end
      end
      if (cmd.fail) begin
        next_start_r <= '0;
      end
      if (cmd.commit) begin
        next_start_r <= hit_idx_r;
        free_slots_r <= free_slots_r - 1'b1;
      end
      if (cmd.free_wr) begin
        next_start_r <= free_idx_r;
        if (free_slots_r < n) begin
          free_slots_r <= free_slots_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_alloc) begin
      pass_r       <= ~start_in;
      scan_word_r  <= start_in ? start_word : '0;
      first_pend_r <= start_in;
      start_bit_r  <= next_start_r[SWB_LG-1:0];
    end else if (cmd.scan) begin
      chk_word_r   <= scan_word_r;
      chk_first_r  <= issue_r & first_pend_r;
      chk_last_r   <= issue_r & pass_r & (scan_word_r == last_word);
      first_pend_r <= 1'b0;
      if (issue_r) begin
        if (scan_word_r == last_word) begin
          if (!pass_r) begin
            scan_word_r <= '0;
            pass_r      <= 1'b1;
          end
        end else begin
          scan_word_r <= scan_word_r + 1'b1;
        end
      end
    end
    if (cmd.acc_free) begin
      scan_word_r <= in_data.slot_index >> SWB_LG;
      free_idx_r  <= in_data.slot_index;
    end
    if (cmd.take_hit) begin
      hit_idx_r <= IDX_W'({chk_word_r, enc});
      wdata_r   <= rdata_r | (SWB'(1) << enc);
    end
    if (cmd.reject) begin
      out_r.status        <= (in_data.req_type == REQ_FREE) ? ST_RANGE : ST_NO_FREE;
      out_r.granted_index <= '0;
      out_r.slot_offset   <= '0;
      out_r.free_count    <= free_slots_r;
    end else if (cmd.fail) begin
      out_r.status        <= ST_INCONSISTENT;
      out_r.granted_index <= '0;
      out_r.slot_offset   <= '0;
      out_r.free_count    <= free_slots_r;
    end else if (cmd.commit) begin
      out_r.status        <= ST_OK;
      out_r.granted_index <= hit_idx_r;
      out_r.slot_offset   <= offset;
      out_r.free_count    <= free_slots_r - 1'b1;
    end else if (cmd.free_wr) begin
      out_r.status        <= ST_OK;
      out_r.granted_index <= '0;
      out_r.slot_offset   <= '0;
      out_r.free_count    <= (free_slots_r < n) ? free_slots_r + 1'b1 : free_slots_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_free_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    free_slots_r <= n)
    else $error("free slot count exceeds slot count");

  a_hit_was_clear: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.take_hit |-> !rdata_r[enc])
    else $error("granted slot was already occupied");

  a_hit_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.take_hit && chk_first_r) |-> (enc >= start_bit_r))
    else $error("first scan word granted a slot below the start index");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && (out_r.status != ST_OK)) |->
      ((out_r.granted_index == '0) && (out_r.slot_offset == '0)))
    else $error("failed transaction carries a non-zero index or offset");

endmodule
